/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the free block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/gfba_pkg.sv */
// Shared types, codes and a helper function of the grouped free block allocator.
package gfba_pkg;

   localparam int BLK_W       = 10;
   localparam int CNT_W       = 11;
   localparam int BLOCK_COUNT = 1024;

   localparam logic [CNT_W-1:0] FREE_MAX = 11'd2047;

   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_CORRUPT = 2'd3;

   localparam logic CSR_DATA_START  = 1'b0;
   localparam logic CSR_DATA_BLOCKS = 1'b1;

   typedef logic [2:0] op_type;

   localparam op_type OP_NONE       = 3'd0;
   localparam op_type OP_PUSH       = 3'd1;
   localparam op_type OP_POP        = 3'd2;
   localparam op_type OP_CLEAR      = 3'd3;
   localparam op_type OP_SPILL_END  = 3'd4;
   localparam op_type OP_RELOAD_END = 3'd5;

   typedef struct packed {
      logic       accept;
      logic       cnt_clear;
      logic       spill_wr;
      logic       reload_rd;
      logic       commit;
      op_type     op;
      logic [1:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       blk_ok;
      logic       fc_zero;
      logic       fc_one;
      logic       fc_max;
      logic       hc_zero;
      logic       hc_many;
      logic       hc_full;
      logic       hc_over;
      logic       head0_ok;
      logic       cnt_last;
      logic       bad;
      logic       out_free;
   } dp_sts_type;

   // A block is usable when it lies inside the configured data area.
   function automatic logic block_ok(input logic [BLK_W-1:0] blk,
                                     input logic [BLK_W-1:0] start,
                                     input logic [CNT_W-1:0] blocks);
      logic [BLK_W-1:0] offset;
      offset = blk - start;
      return (blk >= start) && ({1'b0, offset} < blocks);
   endfunction

endpackage

/* hdl/gfba_datapath.sv */
// Datapath of the allocator: head group, counters, spill memory and result word.
module gfba_datapath #(
   parameter int GROUP_SIZE = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_index,
   input  logic [10:0]                   csr_data,
   input  logic [1:0]                    req_kind,
   input  logic [9:0]                    req_block_num,
   input  gfba_pkg::ctl_cmd_type         cmd,
   output gfba_pkg::dp_sts_type          sts,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [9:0]                    rsp_allocated_block,
   output logic [1:0]                    rsp_status,
   output logic [10:0]                   rsp_free_total
);
   import gfba_pkg::*;

   localparam int IDX_W     = $clog2(GROUP_SIZE);
   localparam int HC_W      = $clog2(GROUP_SIZE + 1);
   localparam int ADDR_W    = BLK_W + IDX_W;
   localparam int MEM_DEPTH = BLOCK_COUNT << IDX_W;

   localparam logic [HC_W-1:0]  HC_ONE  = HC_W'(1);
   localparam logic [HC_W-1:0]  HC_FULL = HC_W'(GROUP_SIZE);
   localparam logic [IDX_W-1:0] IDX_END = IDX_W'(GROUP_SIZE - 1);
   localparam logic [CNT_W-1:0] FC_ONE  = CNT_W'(1);

   logic [BLK_W-1:0]  ds_ff;
   logic [CNT_W-1:0]  db_ff;
   logic [1:0]        kind_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [BLK_W-1:0]  head_ff [GROUP_SIZE];
   logic [HC_W-1:0]   hc_ff, hc_in;
   logic [CNT_W-1:0]  fc_ff, fc_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BLK_W-1:0]  spill_mem [MEM_DEPTH];
   logic [BLK_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_valid_ff;
   logic              bad_ff;
   logic [BLK_W-1:0]  stage0_ff;
   logic              rsp_valid_ff;
   logic [BLK_W-1:0]  rsp_blk_ff;
   logic [1:0]        rsp_st_ff;
   logic [CNT_W-1:0]  rsp_fc_ff;

   logic [HC_W-1:0]   hc_dec;
   logic [IDX_W-1:0]  hd_raddr;
   logic [BLK_W-1:0]  hd_rdata;
   logic [ADDR_W-1:0] mem_addr;
   logic [BLK_W-1:0]  alloc_in;

   assign hc_dec   = hc_ff - HC_ONE;
   assign hd_raddr = cmd.spill_wr ? idx_ff : hc_dec[IDX_W-1:0];
   assign hd_rdata = head_ff[hd_raddr];
   assign mem_addr = {(cmd.spill_wr ? blk_ff : head_ff[0]), idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff <= '0;
         db_ff <= 11'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DATA_START:  ds_ff <= csr_data[BLK_W-1:0];
            CSR_DATA_BLOCKS: db_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         blk_ff  <= req_block_num;
      end
   end

   always_comb begin
      hc_in = hc_ff;
      fc_in = fc_ff;
      if (cmd.commit) begin
         case (cmd.op)
            OP_PUSH: begin
               hc_in = hc_ff + HC_ONE;
               fc_in = fc_ff + FC_ONE;
            end
            OP_POP: begin
               hc_in = hc_dec;
               fc_in = fc_ff - FC_ONE;
            end
            OP_CLEAR: begin
               hc_in = '0;
               fc_in = '0;
            end
            OP_SPILL_END: begin
               hc_in = HC_ONE;
               fc_in = fc_ff + FC_ONE;
            end
            OP_RELOAD_END: begin
               hc_in = HC_FULL;
               fc_in = fc_ff - FC_ONE;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.cnt_clear) begin
         idx_in = '0;
      end else if (cmd.spill_wr || cmd.reload_rd) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      case (cmd.op)
         OP_POP:        alloc_in = hd_rdata;
         OP_RELOAD_END: alloc_in = head_ff[0];
         default:       alloc_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff       <= '0;
         fc_ff       <= '0;
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
         bad_ff      <= 1'b0;
      end else begin
         hc_ff       <= hc_in;
         fc_ff       <= fc_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= cmd.reload_rd;
         if (cmd.cnt_clear) begin
            bad_ff <= 1'b0;
         end else if (rd_valid_ff && !block_ok(rd_data_ff, ds_ff, db_ff)) begin
            bad_ff <= 1'b1;
         end
      end
   end

   // Entry zero of a reloaded group waits aside so the linking block stays at the head.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         case (cmd.op)
            OP_PUSH:       head_ff[hc_ff[IDX_W-1:0]] <= blk_ff;
            OP_SPILL_END:  head_ff[0] <= blk_ff;
            OP_RELOAD_END: head_ff[0] <= stage0_ff;
            default: ;
         endcase
      end
      if (rd_valid_ff) begin
         if (rd_idx_ff == '0) begin
            stage0_ff <= rd_data_ff;
         end else begin
            head_ff[rd_idx_ff] <= rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.spill_wr) begin
         spill_mem[mem_addr] <= hd_rdata;
      end
      rd_data_ff <= spill_mem[mem_addr];
      rd_idx_ff  <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_blk_ff <= alloc_in;
         rsp_st_ff  <= cmd.status;
         rsp_fc_ff  <= fc_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_blk_ff;
   assign rsp_status          = rsp_st_ff;
   assign rsp_free_total      = rsp_fc_ff;

   assign sts.kind     = kind_ff;
   assign sts.blk_ok   = block_ok(blk_ff, ds_ff, db_ff);
   assign sts.fc_zero  = (fc_ff == '0);
   assign sts.fc_one   = (fc_ff == FC_ONE);
   assign sts.fc_max   = (fc_ff >= FREE_MAX);
   assign sts.hc_zero  = (hc_ff == '0);
   assign sts.hc_many  = (hc_ff > HC_ONE);
   assign sts.hc_full  = (hc_ff >= HC_FULL);
   assign sts.hc_over  = (hc_ff > HC_FULL);
   assign sts.head0_ok = block_ok(head_ff[0], ds_ff, db_ff);
   assign sts.cnt_last = (idx_ff == IDX_END);
   assign sts.bad      = bad_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

/* hdl/gfba_controller.sv */
// Controller state machine that sequences each allocator request through the datapath.
module gfba_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gfba_pkg::dp_sts_type  sts,
   output gfba_pkg::ctl_cmd_type cmd
);
   import gfba_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SPILL  = 3'd2;
   localparam logic [2:0] S_RELOAD = 3'd3;
   localparam logic [2:0] S_TAIL   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   op_type     op_ff, op_in;
   logic [1:0] st_ff, st_in;
   logic       reload_bad;

   assign req_stall  = (state_ff != S_IDLE);
   assign reload_bad = (op_ff == OP_RELOAD_END) && sts.bad;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      st_in         = st_ff;
      cmd           = '0;
      cmd.op        = reload_bad ? OP_NONE : op_ff;
      cmd.status    = reload_bad ? ST_CORRUPT : st_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            op_in    = OP_NONE;
            st_in    = ST_OK;
            state_in = S_FINISH;
            case (sts.kind)
               KIND_ALLOC: begin
                  if (sts.fc_zero) begin
                     st_in = ST_NOSPACE;
                  end else if (sts.hc_zero || sts.hc_over) begin
                     st_in = ST_CORRUPT;
                  end else if (sts.hc_many || sts.fc_one) begin
                     op_in = OP_POP;
                  end else if (!sts.head0_ok) begin
                     st_in = ST_INVALID;
                  end else begin
                     op_in         = OP_RELOAD_END;
                     cmd.cnt_clear = 1'b1;
                     state_in      = S_RELOAD;
                  end
               end
               KIND_FREE: begin
                  if (!sts.blk_ok) begin
                     st_in = ST_INVALID;
                  end else if (sts.fc_max) begin
                     st_in = ST_CORRUPT;
                  end else if (!sts.hc_full) begin
                     op_in = OP_PUSH;
                  end else begin
                     op_in         = OP_SPILL_END;
                     cmd.cnt_clear = 1'b1;
                     state_in      = S_SPILL;
                  end
               end
               KIND_CLEAR: begin
                  op_in = OP_CLEAR;
               end
               default: ;
            endcase
         end
         S_SPILL: begin
            cmd.spill_wr = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_FINISH;
            end
         end
         S_RELOAD: begin
            cmd.reload_rd = 1'b1;
            if (sts.cnt_last) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_NONE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         st_ff    <= st_in;
      end
   end

endmodule

/* hdl/grouped_free_block_allocator.sv */
// Grouped free block allocator: one request word in, one response word out per request; a
// clear, a plain free, an allocate that pops the head group or a rejected request goes from
// accept through the decide and finish states, a free that spills the full head group adds a
// spill state with one spill memory write per entry, and an allocate that reloads a group adds
// a reload state with one spill memory read per entry plus a tail state for the registered read; a
// response waiting in the output register does not hold off the next request, but the next
// response waits until it is taken.
`include "assert_macros.svh"

module grouped_free_block_allocator #(
   parameter int GROUP_SIZE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_block_num,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_allocated_block,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_free_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);
   import gfba_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   assign csr_ready = 1'b1;

   gfba_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gfba_datapath #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_kind            (req_kind),
      .req_block_num       (req_block_num),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .rsp_free_total      (rsp_free_total)
   );

   `ASSERT_IMPL(a_commit_needs_room, clock, reset, cmd.commit, sts.out_free)
   `ASSERT_NEXT(a_commit_shows_word, clock, reset, cmd.commit, rsp_valid)
   `ASSERT_NEXT(a_accept_goes_busy, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPL(a_one_memory_op, clock, reset, cmd.spill_wr, !cmd.reload_rd && !cmd.commit)

endmodule

/* bench/gfba_response_checker.sv */
// Response checker for the grouped free block allocator: tracks the pool and compares words.
`timescale 1ns / 1ps

module gfba_response_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_block_num,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_allocated_block,
   input  logic [1:0]  rsp_status,
   input  logic [10:0] rsp_free_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data,
   output int unsigned outstanding,
   output int unsigned failures
);
   import gfba_pkg::*;

   localparam int GROUP = 16;

   typedef struct packed {
      logic [9:0]  blk;
      logic [1:0]  status;
      logic [10:0] total;
   } alloc_rsp_type;

   bit [9:0]      area_start;
   bit [10:0]     area_blocks;
   bit [9:0]      head_q [GROUP];
   int unsigned   head_len;
   int unsigned   free_len;
   bit [9:0]      spill_blk [BLOCK_COUNT][GROUP];
   int unsigned   spill_len [BLOCK_COUNT];
   alloc_rsp_type due_q [$];
   int unsigned   fail_total = 0;

   function automatic bit in_area(input bit [9:0] b);
      return (b >= area_start) && ((int'(b) - int'(area_start)) < int'(area_blocks));
   endfunction

   // Applies one request word to the tracked pool and returns the response it must produce.
   function automatic alloc_rsp_type apply_request(input logic [1:0] kind, input logic [9:0] b);
      alloc_rsp_type r;
      bit [9:0]      link;
      int unsigned   n;
      bit            ok;
      int            i;
      r = '0;
      case (kind)
         KIND_ALLOC: begin
            if (free_len == 0) begin
               r.status = ST_NOSPACE;
            end else if (head_len == 0 || head_len > GROUP) begin
               r.status = ST_CORRUPT;
            end else if (head_len > 1 || free_len == 1) begin
               head_len--;
               r.blk = head_q[head_len];
               free_len--;
            end else begin
               link = head_q[0];
               if (!in_area(link)) begin
                  r.status = ST_INVALID;
               end else begin
                  n = spill_len[link];
                  ok = (n <= GROUP);
                  for (i = 0; i < n && i < GROUP; i++) begin
                     if (!in_area(spill_blk[link][i])) ok = 1'b0;
                  end
                  if (!ok) begin
                     r.status = ST_CORRUPT;
                  end else begin
                     for (i = 0; i < n; i++) head_q[i] = spill_blk[link][i];
                     head_len = n;
                     free_len--;
                     r.blk = link;
                  end
               end
            end
         end
         KIND_FREE: begin
            if (!in_area(b)) begin
               r.status = ST_INVALID;
            end else if (free_len >= FREE_MAX) begin
               r.status = ST_CORRUPT;
            end else begin
               if (head_len < GROUP) begin
                  head_q[head_len] = b;
                  head_len++;
               end else begin
                  for (i = 0; i < GROUP; i++) spill_blk[b][i] = head_q[i];
                  spill_len[b] = head_len;
                  head_q[0] = b;
                  head_len = 1;
               end
               free_len++;
            end
         end
         KIND_CLEAR: begin
            head_len = 0;
            free_len = 0;
         end
         default: begin
         end
      endcase
      r.total = 11'(free_len);
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_rsp_type want;
      if (reset) begin
         area_start = '0;
         area_blocks = 11'd1024;
         head_len = 0;
         free_len = 0;
         due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DATA_START) area_start = csr_data[9:0];
            else area_blocks = csr_data;
         end
         if (req_valid && !req_stall) due_q.push_back(apply_request(req_kind, req_block_num));
         if (rsp_valid && !rsp_stall) begin
            if (due_q.size() == 0) begin
               fail_total++;
               $display("%0t: response word with none expected: block %0d status %0d total %0d",
                        $time, rsp_allocated_block, rsp_status, rsp_free_total);
            end else begin
               want = due_q.pop_front();
               if (rsp_allocated_block !== want.blk) begin
                  fail_total++;
                  $display("%0t: allocated_block expected %0d, actual %0d",
                           $time, want.blk, rsp_allocated_block);
               end
               if (rsp_status !== want.status) begin
                  fail_total++;
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_free_total !== want.total) begin
                  fail_total++;
                  $display("%0t: free_total expected %0d, actual %0d",
                           $time, want.total, rsp_free_total);
               end
            end
         end
      end
      outstanding <= due_q.size();
      failures <= fail_total;
   end

endmodule

/* bench/tb_grouped_free_block_allocator.sv */
// Top-level testbench of the grouped free block allocator: stimulus, clocking and verdict.
`timescale 1ns / 1ps

module tb_grouped_free_block_allocator;

   import gfba_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef enum int {RX_RANDOM, RX_NONE, RX_HOLD} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [9:0]  req_block_num = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_allocated_block;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_free_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [10:0] csr_data = '0;

   int unsigned outstanding;
   int unsigned failures;
   int unsigned cycle_count = 0;
   bit          tx_fast = 1'b0;
   rx_mode_type rx_mode = RX_RANDOM;
   logic [9:0]  area_start = '0;
   logic [10:0] area_blocks = 11'd1024;

   grouped_free_block_allocator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_block_num       (req_block_num),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .rsp_free_total      (rsp_free_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   gfba_response_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_block_num       (req_block_num),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .rsp_free_total      (rsp_free_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .outstanding         (outstanding),
      .failures            (failures)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The receiver takes response words; a hold request keeps it stalled for a long stretch.
   initial begin
      int unsigned wait_n;
      forever begin
         if (rx_mode == RX_HOLD) begin
            wait_n = HOLD_CYCLES;
            rx_mode = RX_RANDOM;
         end else if (rx_mode == RX_NONE) begin
            wait_n = 0;
         end else begin
            wait_n = $urandom_range(19, 0);
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_req(input logic [1:0] kind, input logic [9:0] blk);
      int unsigned gap;
      gap = tx_fast ? 0 : $urandom_range(19, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_block_num <= blk;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_area(input logic [9:0] start, input logic [10:0] blocks);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_DATA_START;
      csr_data <= {1'b0, start};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_DATA_BLOCKS;
      csr_data <= blocks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      area_start = start;
      area_blocks = blocks;
   endtask

   function automatic logic [9:0] pick_block();
      int unsigned hi;
      hi = area_start + area_blocks - 1;
      if (hi > 1023) hi = 1023;
      if ($urandom_range(99, 0) < 85) return 10'($urandom_range(hi, area_start));
      return 10'($urandom_range(1023, 0));
   endfunction

   task automatic random_run(input int unsigned count, input int unsigned free_pct);
      int unsigned i;
      int unsigned r;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(99, 0);
         if (r < free_pct) send_req(KIND_FREE, pick_block());
         else if (r < free_pct + 2) send_req(KIND_CLEAR, 10'($urandom_range(1023, 0)));
         else if (r < free_pct + 4) send_req(KIND_SPARE, 10'($urandom_range(1023, 0)));
         else send_req(KIND_ALLOC, 10'($urandom_range(1023, 0)));
      end
   endtask

   initial begin
      int unsigned i;
      int unsigned p;
      int unsigned sel;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_area(10'd0, 11'd1024);
      send_req(KIND_ALLOC, 10'd0);
      send_req(KIND_SPARE, 10'd1023);
      send_req(KIND_FREE, 10'd0);
      send_req(KIND_FREE, 10'd1023);
      for (i = 200; i < 214; i++) send_req(KIND_FREE, 10'(i));
      send_req(KIND_FREE, 10'd300);
      send_req(KIND_FREE, 10'd301);
      repeat (3) send_req(KIND_ALLOC, 10'd0);
      send_req(KIND_CLEAR, 10'd0);
      send_req(KIND_ALLOC, 10'd0);

      // Two linked groups, then a data area that makes the inner group or the link unusable.
      for (i = 500; i < 516; i++) send_req(KIND_FREE, 10'(i));
      send_req(KIND_FREE, 10'd600);
      for (i = 700; i < 715; i++) send_req(KIND_FREE, 10'(i));
      send_req(KIND_FREE, 10'd800);
      set_area(10'd601, 11'd423);
      send_req(KIND_ALLOC, 10'd0);
      send_req(KIND_FREE, 10'd100);
      set_area(10'd0, 11'd700);
      send_req(KIND_ALLOC, 10'd0);
      set_area(10'd0, 11'd1024);
      send_req(KIND_ALLOC, 10'd0);
      send_req(KIND_ALLOC, 10'd0);
      set_area(10'd1023, 11'd1);
      send_req(KIND_ALLOC, 10'd0);
      send_req(KIND_FREE, 10'd1023);
      send_req(KIND_FREE, 10'd1022);
      set_area(10'd0, 11'd1);
      send_req(KIND_FREE, 10'd0);
      send_req(KIND_FREE, 10'd1);
      set_area(10'd1000, 11'd1024);
      send_req(KIND_FREE, 10'd1023);
      send_req(KIND_FREE, 10'd999);
      set_area(10'd0, 11'd1024);

      rx_mode = RX_HOLD;
      repeat (40) send_req(KIND_FREE, pick_block());
      drain();

      for (p = 0; p < 16; p++) begin
         sel = $urandom_range(5, 0);
         case (sel)
            0: set_area(10'd0, 11'd1024);
            1: set_area(10'd0, 11'd1);
            2: set_area(10'd1023, 11'd1);
            3: set_area(10'd1023, 11'd1024);
            default: set_area(10'($urandom_range(1023, 0)), 11'($urandom_range(1024, 1)));
         endcase
         tx_fast = ($urandom_range(3, 0) == 0);
         rx_mode = ($urandom_range(3, 0) == 0) ? RX_NONE : RX_RANDOM;
         if ($urandom_range(2, 0) == 0) send_req(KIND_CLEAR, 10'd0);
         random_run(90, (p % 3 == 0) ? 75 : ((p % 3 == 1) ? 55 : 35));
      end

      drain();
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
